// ----- hdl/bpa_pkg.sv -----
// Shared widths, op and status codes and reset value of bitmap page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int PAGE_W  = 16;
  localparam int COUNT_W = 17;

  localparam logic [1:0] OP_ALLOC     = 2'd0;
  localparam logic [1:0] OP_FREE      = 2'd1;
  localparam logic [1:0] OP_MARK_FREE = 2'd2;
  localparam logic [1:0] OP_MARK_USED = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic [COUNT_W-1:0] LOW_RESERVED_RESET = 17'h00100;

endpackage

// ----- hdl/bpa_div.sv -----
// Split of a page number into bitmap word address and bit position for a power-of-two word size.
`timescale 1ns / 1ps

module bpa_div #(
  parameter int DIVISOR = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [bpa_pkg::PAGE_W-1:0]        dividend,
  output logic                              done,
  output logic [bpa_pkg::PAGE_W-1:0]        quotient,
  output logic [$clog2(DIVISOR)-1:0]        remainder
);

  localparam int BW = $clog2(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // The word size is a power of two, so the split is a shift and a mask.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend >> BW;
      remainder <= dividend[BW-1:0];
    end
  end

endmodule

// ----- hdl/bitmap_page_allocator.sv -----
// Top level of the bitmap page allocator: bitmap memory, sequencer and register port.
//
//  Channel   Signals                                     Direction  Beat taken when
//  request   start, busy, op, page_index                 in         start && !busy
//  result    done, status, page_index_res, free_pages    out        every cycle done is high
//  config    psel, penable, pwrite, paddr, pwdata,       in/out     psel && penable && pwrite
//            prdata, pready
//
// Free, mark-free and mark-used register the word/bit split, read the word, then test and
// write it back; their result beat is registered in the S_MOD state.
// Alloc scans the bitmap one word at a time, a memory read in S_SCAN and then a search of
// the word in S_SEV; a hit ends the scan with ST_DONE, a miss over all words below the limit
// with ST_NO_FREE. A request rejected at once gives its result beat at the next edge.
// After reset a clearing pass marks every page used, one word per cycle, over all
// ceil(PAGES / WORD_BITS) words; busy is high and no request is taken meanwhile.
// The result beat cannot be stalled; busy is the only flow control.
`timescale 1ns / 1ps

module bitmap_page_allocator #(
  parameter int PAGES     = 65536,
  parameter int WORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        op,
  input  logic [bpa_pkg::PAGE_W-1:0]        page_index,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [bpa_pkg::PAGE_W-1:0]        page_index_res,
  output logic [bpa_pkg::COUNT_W-1:0]       free_pages,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int PW     = bpa_pkg::PAGE_W;
  localparam int CNTW   = bpa_pkg::COUNT_W;
  localparam int NWORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int BASEW  = CNTW + 1;
  localparam int SPAN   = (PAGES < 65536) ? PAGES : 65536;

  localparam logic [CNTW-1:0]  SPAN_C    = CNTW'(SPAN);
  localparam logic [AW-1:0]    LAST_WORD = AW'(NWORDS - 1);
  localparam logic [BASEW-1:0] WORD_STEP = BASEW'(WORD_BITS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_SEV   = 3'd5;

  logic [2:0]            state;
  logic [CNTW-1:0]       managed_pages;
  logic [CNTW-1:0]       low_reserved_pages;
  logic [CNTW-1:0]       free_count;
  logic [1:0]            op_q;
  logic [PW-1:0]         page_q;
  logic [AW-1:0]         waddr;
  logic [BASEW-1:0]      base;

  logic [WORD_BITS-1:0]  mem [NWORDS];
  logic [WORD_BITS-1:0]  rd_data;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [WORD_BITS-1:0]  mem_wd;
  logic [AW-1:0]         mem_ra;

  logic                  div_start;
  logic                  div_done;
  logic [PW-1:0]         div_q;
  logic [BW-1:0]         div_r;
  logic [AW+PW-1:0]      q_ext;
  logic [AW-1:0]         q_addr;

  logic [CNTW-1:0]       lim;
  logic                  accept;
  logic                  range_ok;
  logic [BASEW-1:0]      scan_left;
  logic [WORD_BITS-1:0]  free_bits;
  logic                  hit;
  logic [BW-1:0]         hit_idx;
  logic                  cur_bit;
  logic                  changes;
  logic [WORD_BITS-1:0]  bit_mask;
  logic [CNTW-1:0]       count_inc;
  logic [CNTW-1:0]       count_dec;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      managed_pages      <= '0;
      low_reserved_pages <= bpa_pkg::LOW_RESERVED_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        low_reserved_pages <= pwdata[CNTW-1:0];
      end else begin
        managed_pages <= pwdata[CNTW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2]) begin
      prdata[CNTW-1:0] = low_reserved_pages;
    end else begin
      prdata[CNTW-1:0] = managed_pages;
    end
  end

  // Bitmap memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  bpa_div #(
    .DIVISOR (WORD_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (page_index),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign q_ext  = {{AW{1'b0}}, div_q};
  assign q_addr = q_ext[AW-1:0];

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign lim    = (managed_pages < SPAN_C) ? managed_pages : SPAN_C;

  always_comb begin
    case (op)
      bpa_pkg::OP_FREE:      range_ok = {1'b0, page_index} < lim;
      bpa_pkg::OP_MARK_FREE: range_ok = ({1'b0, page_index} < lim) &&
                                        ({1'b0, page_index} >= low_reserved_pages);
      bpa_pkg::OP_MARK_USED: range_ok = {1'b0, page_index} < SPAN_C;
      default:               range_ok = 1'b0;
    endcase
  end

  assign div_start = accept && (op != bpa_pkg::OP_ALLOC) && range_ok;

  // Search of one bitmap word: only pages below the limit count.
  assign scan_left = {1'b0, lim} - base;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      free_bits[b] = !rd_data[b] && (BASEW'(b) < scan_left);
    end
    hit     = |free_bits;
    hit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit_idx = BW'(b);
      end
    end
  end

  assign cur_bit  = rd_data[div_r];
  assign changes  = (op_q == bpa_pkg::OP_MARK_USED) ? !cur_bit : cur_bit;
  assign bit_mask = (state == S_SEV) ? (WORD_BITS'(1) << hit_idx)
                                     : (WORD_BITS'(1) << div_r);

  assign count_inc = free_count + CNTW'(1);
  assign count_dec = (free_count != '0) ? free_count - CNTW'(1) : free_count;

  always_comb begin
    mem_ra = (state == S_DIV) ? q_addr : waddr;
    mem_we = 1'b0;
    mem_wa = waddr;
    mem_wd = rd_data | bit_mask;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = '1;
      end
      S_SEV: begin
        mem_we = hit;
      end
      S_MOD: begin
        mem_we = changes;
        if (op_q != bpa_pkg::OP_MARK_USED) begin
          mem_wd = rd_data & ~bit_mask;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      waddr      <= '0;
      free_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (waddr == LAST_WORD) begin
            state <= S_IDLE;
          end
          waddr <= waddr + AW'(1);
        end
        S_IDLE: begin
          if (accept) begin
            op_q   <= op;
            page_q <= page_index;
            if (op == bpa_pkg::OP_ALLOC) begin
              waddr <= '0;
              base  <= '0;
              state <= S_SCAN;
            end else if (range_ok) begin
              state <= S_DIV;
            end else begin
              done           <= 1'b1;
              status         <= bpa_pkg::ST_IGNORED;
              page_index_res <= page_index;
              free_pages     <= free_count;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            waddr <= q_addr;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          done           <= 1'b1;
          page_index_res <= page_q;
          state          <= S_IDLE;
          if (changes) begin
            status <= bpa_pkg::ST_DONE;
            if (op_q == bpa_pkg::OP_MARK_USED) begin
              free_count <= count_dec;
              free_pages <= count_dec;
            end else begin
              free_count <= count_inc;
              free_pages <= count_inc;
            end
          end else begin
            status     <= bpa_pkg::ST_IGNORED;
            free_pages <= free_count;
          end
        end
        S_SCAN: begin
          // The read of the word at waddr is issued in this cycle.
          if (base < {1'b0, lim}) begin
            state <= S_SEV;
          end else begin
            done           <= 1'b1;
            status         <= bpa_pkg::ST_NO_FREE;
            page_index_res <= '0;
            free_pages     <= free_count;
            state          <= S_IDLE;
          end
        end
        S_SEV: begin
          if (hit) begin
            done           <= 1'b1;
            status         <= bpa_pkg::ST_DONE;
            page_index_res <= base[PW-1:0] + PW'(hit_idx);
            free_count     <= count_dec;
            free_pages     <= count_dec;
            state          <= S_IDLE;
          end else begin
            waddr <= waddr + AW'(1);
            base  <= base + WORD_STEP;
            state <= S_SCAN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
